[hdl/sfd_pkg.sv]
// shared types and constants for the frame deframer
package sfd_pkg;

  localparam int FRAME_LEN_DEF = 14;
  localparam int POS_W         = 6;
  localparam int BYTE_W        = 8;
  localparam int TALLY_W       = 32;

  localparam logic [BYTE_W-1:0] OPEN_MARK = 8'hA5;

  typedef enum logic [1:0] {
    EV_STRAY = 2'd0,
    EV_TAKEN = 2'd1,
    EV_GOOD  = 2'd2,
    EV_BAD   = 2'd3
  } event_t;

  // one classified byte handed from front to back
  typedef struct packed {
    event_t              ev;
    logic [POS_W-1:0]    pos;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   check;
  } cmd_t;

endpackage

[hdl/sfd_front.sv]
// front end: frame tracking, running xor and byte classification
module sfd_front #(
  parameter int FRAME_LEN = sfd_pkg::FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        push,
  output sfd_pkg::cmd_t               push_cmd,
  input  logic                        q_full
);

  localparam logic [sfd_pkg::POS_W-1:0] LAST = sfd_pkg::POS_W'(FRAME_LEN - 1);

  logic                        in_frame_r, in_frame_nxt;
  logic [sfd_pkg::POS_W-1:0]   position_r, position_nxt;
  logic [sfd_pkg::BYTE_W-1:0]  check_r, check_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    position_nxt   = position_r;
    check_nxt      = check_r;
    push_cmd.pos   = position_r;
    push_cmd.data  = in_rx_byte;
    push_cmd.check = check_r;
    push_cmd.ev    = sfd_pkg::EV_TAKEN;
    if (!in_frame_r) begin
      if (in_rx_byte == sfd_pkg::OPEN_MARK) begin
        in_frame_nxt = 1'b1;
        position_nxt = sfd_pkg::POS_W'(1);
        check_nxt    = in_rx_byte;
      end else begin
        push_cmd.ev = sfd_pkg::EV_STRAY;
      end
    end else if (position_r == LAST) begin
      // last byte is the check byte, frame closes either way
      push_cmd.ev  = (check_r == in_rx_byte) ? sfd_pkg::EV_GOOD : sfd_pkg::EV_BAD;
      in_frame_nxt = 1'b0;
      position_nxt = '0;
      check_nxt    = '0;
    end else begin
      check_nxt    = check_r ^ in_rx_byte;
      position_nxt = position_r + sfd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      position_r <= '0;
      check_r    <= '0;
    end else if (push) begin
      in_frame_r <= in_frame_nxt;
      position_r <= position_nxt;
      check_r    <= check_nxt;
    end
  end

endmodule

[hdl/sfd_queue.sv]
// two-entry queue between front and back
module sfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfd_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output sfd_pkg::cmd_t  pop_cmd
);

  sfd_pkg::cmd_t mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_cmd   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hdl/sfd_back.sv]
// back end: header capture, held fields, tallies and the result register
module sfd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  sfd_pkg::cmd_t               q_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_res
);

  logic                          out_valid_r;
  sfd_pkg::event_t               out_event_r;
  logic [sfd_pkg::BYTE_W-1:0]    cap_src_r, cap_dst_r, cap_type_r;
  logic [2*sfd_pkg::BYTE_W-1:0]  cap_seq_r;
  logic [sfd_pkg::BYTE_W-1:0]    held_src_r, held_dst_r, held_type_r;
  logic [2*sfd_pkg::BYTE_W-1:0]  held_seq_r;
  logic [sfd_pkg::BYTE_W-1:0]    held_want_r, held_got_r;
  logic [sfd_pkg::TALLY_W-1:0]   byte_tally_r, good_tally_r, bad_tally_r, stray_tally_r;

  // take a beat whenever the result register is free or draining
  assign pop           = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_event_r <= q_cmd.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_src_r     <= '0;
      cap_dst_r     <= '0;
      cap_type_r    <= '0;
      cap_seq_r     <= '0;
      held_src_r    <= '0;
      held_dst_r    <= '0;
      held_type_r   <= '0;
      held_seq_r    <= '0;
      held_want_r   <= '0;
      held_got_r    <= '0;
      byte_tally_r  <= '0;
      good_tally_r  <= '0;
      bad_tally_r   <= '0;
      stray_tally_r <= '0;
    end else if (pop) begin
      byte_tally_r <= byte_tally_r + sfd_pkg::TALLY_W'(1);
      case (q_cmd.ev)
        sfd_pkg::EV_STRAY: begin
          stray_tally_r <= stray_tally_r + sfd_pkg::TALLY_W'(1);
        end
        sfd_pkg::EV_TAKEN: begin
          // header bytes follow the opening mark
          case (q_cmd.pos)
            sfd_pkg::POS_W'(1): cap_src_r  <= q_cmd.data;
            sfd_pkg::POS_W'(2): cap_dst_r  <= q_cmd.data;
            sfd_pkg::POS_W'(3): cap_type_r <= q_cmd.data;
            sfd_pkg::POS_W'(4): cap_seq_r[sfd_pkg::BYTE_W-1:0] <= q_cmd.data;
            sfd_pkg::POS_W'(5): cap_seq_r[2*sfd_pkg::BYTE_W-1:sfd_pkg::BYTE_W] <= q_cmd.data;
            default: ;
          endcase
        end
        sfd_pkg::EV_GOOD: begin
          good_tally_r <= good_tally_r + sfd_pkg::TALLY_W'(1);
          held_want_r  <= q_cmd.check;
          held_got_r   <= q_cmd.data;
          held_src_r   <= cap_src_r;
          held_dst_r   <= cap_dst_r;
          held_type_r  <= cap_type_r;
          held_seq_r   <= cap_seq_r;
        end
        default: begin
          bad_tally_r <= bad_tally_r + sfd_pkg::TALLY_W'(1);
          held_want_r <= q_cmd.check;
          held_got_r  <= q_cmd.data;
        end
      endcase
    end
  end

endmodule

[hdl/sync_frame_deframer_xor_check.sv]
// top level: deframer with front classifier, queue and back end
// an accepted byte is registered in the queue, then in the result register, before its status shows on the output
// throughput: one byte per cycle while the output is not stalled, set by the front update loop
// a stalled output backs up through the two-entry queue to in_ready
// reset: synchronous active-low rst_n closes any frame and clears all
// tallies and held fields
module sync_frame_deframer_xor_check #(
  parameter int FRAME_LEN = sfd_pkg::FRAME_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sfd_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_res
);

  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  sfd_pkg::cmd_t push_cmd;
  sfd_pkg::cmd_t pop_cmd;

  sfd_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  sfd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_cmd         (pop_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res)
  );

endmodule
